// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/krt_pkg.sv =====
// ---------------------------------------------------------------------------
// krt_pkg
// Shared types, codes and helpers of the keyed record table.
// ---------------------------------------------------------------------------
package krt_pkg;

	// Default table depth
	localparam int CAPACITY_DEF = 128;

	// Field widths
	localparam int KEY_W   = 31;
	localparam int SCORE_W = 10;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_MISS = 2'd2;

	// Divide by three: x * 2731 >> 13 is exact for x below 3072
	localparam logic [11:0] MEAN_RECIP = 12'd2731;
	localparam int          MEAN_SHIFT = 13;

	// One stored record
	typedef struct packed {
		logic [SCORE_W-1:0] mean;
		logic [SCORE_W-1:0] third;
		logic [SCORE_W-1:0] second;
		logic [SCORE_W-1:0] first;
		logic [KEY_W-1:0]   key;
	} rec_t;

	// Floor of the three-score sum over three
	function automatic logic [SCORE_W-1:0] mean_of(
		input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b,
		input logic [SCORE_W-1:0] c
	);
		logic [11:0] sum;
		logic [23:0] prod;
		sum  = 12'(a) + 12'(b) + 12'(c);
		prod = 24'(sum) * 24'(MEAN_RECIP);
		return prod[MEAN_SHIFT +: SCORE_W];
	endfunction

endpackage

// ===== hdl/krt_ram.sv =====
// ---------------------------------------------------------------------------
// krt_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/keyed_record_table_top.sv =====
// ---------------------------------------------------------------------------
// keyed_record_table_top
// Unsorted record table with linear key search, held in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word: tuser is the operation (clear, append,
//   delete, update, lookup), tdata the key and three scores. m_axis returns
//   one result word per command: status, index, scores, mean and count.
//   One command is in work at a time; s_axis_tready is high only while the
//   sequencer is idle, so the next command can be taken at the earliest in
//   the cycle after the result loads.
// Flow (from the accepting edge to the raised m_axis_tvalid, receiver ready):
//   clear, append, unused codes: dispatch, then emit to the output register.
//   lookup, update: dispatch, then a scan from index 0 up to the first hit,
//   or past the last of the records held on a miss, then emit.
//   delete: the same search, then a shift-down of every later record by one
//   entry (nothing to copy when the last record goes), then emit.
//   The worst case is a delete in a full table, set by the single RAM read
//   port that both the search and the shift walk one entry per cycle.
// Reset: the record count and all control state clear; RAM contents are
//   left as they are and never read before being written.
// Stall: a finished word sits in the output register while the next
//   command is taken; a command that finishes while that word still waits
//   holds in its last state until the register frees.
// ---------------------------------------------------------------------------
module keyed_record_table_top #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: entry_key[30:0], score_first[40:31], score_second[50:41],
	//        score_third[60:51], zero pad[63:61]
	input  logic [63:0] s_axis_tdata,
	// tuser: operation[2:0]
	input  logic [2:0]  s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: status[1:0], entry_index[8:2], found_first[18:9],
	//        found_second[28:19], found_third[38:29], found_mean[48:39],
	//        record_count[56:49], zero pad[63:57]
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int REC_W = $bits(krt_pkg::rec_t);

	// Sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_SHIFT    = 3'd3;
	localparam logic [2:0] ST_EMIT     = 3'd4;

	logic [2:0]                   state_q;
	logic [krt_pkg::OP_W-1:0]     op_q;
	krt_pkg::rec_t                new_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             rd_ptr_q;
	logic                         rd_valid_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic [IDX_W-1:0]             pos_q;
	krt_pkg::rec_t                rec_q;
	logic [krt_pkg::STAT_W-1:0]   status_q;
	logic                         m_valid_q;
	logic [63:0]                  m_data_q;

	logic                         rd_en;
	logic [IDX_W-1:0]             rd_addr;
	krt_pkg::rec_t                rd_data;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	krt_pkg::rec_t                wr_data;
	logic                         hit;
	logic                         more;
	logic                         full;
	logic                         emit_load;
	logic [krt_pkg::SCORE_W-1:0]  in_first;
	logic [krt_pkg::SCORE_W-1:0]  in_second;
	logic [krt_pkg::SCORE_W-1:0]  in_third;

	assign in_first  = s_axis_tdata[40:31];
	assign in_second = s_axis_tdata[50:41];
	assign in_third  = s_axis_tdata[60:51];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Search / shift helpers
	assign hit  = (state_q == ST_SCAN) && rd_valid_s1 && (rd_data.key == new_q.key);
	assign more = (rd_ptr_q < count_q);
	assign full = (count_q == CNT_W'(CAPACITY));
	assign emit_load = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

	// Read port: walks entries during search and shift
	assign rd_en   = ((state_q == ST_SCAN) && !hit && more) ||
	                 ((state_q == ST_SHIFT) && more);
	assign rd_addr = rd_ptr_q[IDX_W-1:0];

	// Write port: append, update on hit, shift-down copy
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_q;
		if (state_q == ST_DISPATCH && op_q == krt_pkg::OP_APPEND && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
		end else if (hit && op_q == krt_pkg::OP_UPDATE) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
		end else if (state_q == ST_SHIFT && rd_valid_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1 - IDX_W'(1);
			wr_data = rd_data;
		end
	end

	krt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Command capture, mean computed on the way in
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q         <= s_axis_tuser;
			new_q.key    <= s_axis_tdata[30:0];
			new_q.first  <= in_first;
			new_q.second <= in_second;
			new_q.third  <= in_third;
			new_q.mean   <= krt_pkg::mean_of(in_first, in_second, in_third);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					rd_ptr_q    <= '0;
					rd_valid_s1 <= 1'b0;
					case (op_q) inside
						krt_pkg::OP_CLEAR: begin
							count_q <= '0;
							state_q <= ST_EMIT;
						end
						krt_pkg::OP_APPEND: begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_EMIT;
						end
						krt_pkg::OP_DELETE, krt_pkg::OP_UPDATE, krt_pkg::OP_LOOKUP: begin
							state_q <= ST_SCAN;
						end
						default: begin
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_SCAN: begin
					if (hit) begin
						rd_valid_s1 <= 1'b0;
						if (op_q == krt_pkg::OP_DELETE) begin
							rd_ptr_q <= CNT_W'(rd_idx_s1) + CNT_W'(1);
							state_q  <= ST_SHIFT;
						end else begin
							state_q <= ST_EMIT;
						end
					end else if (more) begin
						rd_valid_s1 <= 1'b1;
						rd_idx_s1   <= rd_ptr_q[IDX_W-1:0];
						rd_ptr_q    <= rd_ptr_q + CNT_W'(1);
					end else begin
						rd_valid_s1 <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_SHIFT: begin
					if (more) begin
						rd_valid_s1 <= 1'b1;
						rd_idx_s1   <= rd_ptr_q[IDX_W-1:0];
						rd_ptr_q    <= rd_ptr_q + CNT_W'(1);
					end else begin
						rd_valid_s1 <= 1'b0;
						if (!rd_valid_s1) begin
							count_q <= count_q - CNT_W'(1);
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields: zero unless a record was touched
	always_ff @(posedge clk) begin
		if (state_q == ST_DISPATCH) begin
			status_q <= krt_pkg::STATUS_DONE;
			pos_q    <= '0;
			rec_q    <= '0;
			if (op_q == krt_pkg::OP_APPEND) begin
				if (full) begin
					status_q <= krt_pkg::STATUS_FULL;
				end else begin
					pos_q <= count_q[IDX_W-1:0];
					rec_q <= new_q;
				end
			end
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				pos_q <= rd_idx_s1;
				rec_q <= (op_q == krt_pkg::OP_UPDATE) ? new_q : rd_data;
			end else if (!more) begin
				status_q <= krt_pkg::STATUS_MISS;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_data_q <= {7'd0, 8'(count_q), rec_q.mean, rec_q.third, rec_q.second,
			             rec_q.first, 7'(pos_q), status_q};
		end
	end

endmodule

// ===== hdl/krt_checker.sv =====
// ---------------------------------------------------------------------------
// krt_checker
// Port-level checks of the record table's result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module krt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	logic [krt_pkg::STAT_W-1:0] res_status;
	logic [46:0]                res_fields;
	logic                       stalled;
	logic                       status_ok;
	logic                       failed;

	assign res_status = m_axis_tdata[1:0];
	assign res_fields = m_axis_tdata[48:2];
	assign stalled    = m_axis_tvalid && !m_axis_tready;
	assign status_ok  = (res_status == krt_pkg::STATUS_DONE) ||
	                    (res_status == krt_pkg::STATUS_FULL) ||
	                    (res_status == krt_pkg::STATUS_MISS);
	assign failed     = m_axis_tvalid && (res_status != krt_pkg::STATUS_DONE);

	// Result word held while stalled
	`ASSERT_CLK(a_hold_valid, clk, arst_n, stalled |=> m_axis_tvalid, "word dropped on stall")
	`ASSERT_CLK(a_hold_data, clk, arst_n, stalled |=> $stable(m_axis_tdata), "word changed on stall")

	// Status is one of the three codes
	`ASSERT_CLK(a_status_code, clk, arst_n, m_axis_tvalid |-> status_ok, "illegal status code")

	// Full and miss results carry no record
	`ASSERT_CLK(a_fail_zero, clk, arst_n, failed |-> res_fields == '0, "failed word has fields")

	// Nothing offered while in reset
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

// ===== verif/keyed_record_table_checker.sv =====
// ---------------------------------------------------------------------------
// keyed_record_table_checker
// Watches both stream ports of the record table, keeps a shadow of the table
// contents, and checks every result word against the shadow's prediction.
// ---------------------------------------------------------------------------
module keyed_record_table_checker
	import krt_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output int          fail_count,
	output int          pending,
	output int          checked_count,
	output int          full_count,
	output int          miss_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result word, split into its fields
	typedef struct packed {
		logic [6:0]         pad;
		logic [7:0]         count;
		logic [SCORE_W-1:0] mean;
		logic [SCORE_W-1:0] third;
		logic [SCORE_W-1:0] second;
		logic [SCORE_W-1:0] first;
		logic [6:0]         index;
		logic [STAT_W-1:0]  status;
	} table_result_t;

	// Shadow copy of the table
	logic [KEY_W-1:0]   key_tab    [CAPACITY];
	logic [SCORE_W-1:0] first_tab  [CAPACITY];
	logic [SCORE_W-1:0] second_tab [CAPACITY];
	logic [SCORE_W-1:0] third_tab  [CAPACITY];
	logic [SCORE_W-1:0] mean_tab   [CAPACITY];
	int                 fill = 0;

	table_result_t expected_results [$];

	initial begin
		fail_count    = 0;
		checked_count = 0;
		full_count    = 0;
		miss_count    = 0;
	end

	assign pending = expected_results.size();

	function automatic logic [SCORE_W-1:0] third_of_sum(
		input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b,
		input logic [SCORE_W-1:0] c
	);
		return SCORE_W'((32'(a) + 32'(b) + 32'(c)) / 3);
	endfunction

	// Apply one command to the shadow table, return the word it should produce
	function automatic table_result_t table_apply(
		input logic [OP_W-1:0]    op,
		input logic [KEY_W-1:0]   key,
		input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b,
		input logic [SCORE_W-1:0] c
	);
		table_result_t r;
		int hit;
		r = '0;
		r.status = STATUS_DONE;
		hit = -1;
		case (op)
			OP_CLEAR: begin
				fill = 0;
			end
			OP_APPEND: begin
				if (fill >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					key_tab[fill]    = key;
					first_tab[fill]  = a;
					second_tab[fill] = b;
					third_tab[fill]  = c;
					mean_tab[fill]   = third_of_sum(a, b, c);
					hit = fill;
					fill++;
				end
			end
			OP_DELETE, OP_UPDATE, OP_LOOKUP: begin
				// first match wins
				for (int i = 0; i < fill; i++)
					if (hit < 0 && key_tab[i] == key)
						hit = i;
				if (hit < 0) begin
					r.status = STATUS_MISS;
				end else if (op == OP_UPDATE) begin
					first_tab[hit]  = a;
					second_tab[hit] = b;
					third_tab[hit]  = c;
					mean_tab[hit]   = third_of_sum(a, b, c);
				end
			end
			default: ;
		endcase
		if (hit >= 0) begin
			r.index  = 7'(hit);
			r.first  = first_tab[hit];
			r.second = second_tab[hit];
			r.third  = third_tab[hit];
			r.mean   = mean_tab[hit];
		end
		// delete closes the gap after reporting the removed record
		if (op == OP_DELETE && hit >= 0) begin
			for (int i = hit; i + 1 < fill; i++) begin
				key_tab[i]    = key_tab[i + 1];
				first_tab[i]  = first_tab[i + 1];
				second_tab[i] = second_tab[i + 1];
				third_tab[i]  = third_tab[i + 1];
				mean_tab[i]   = mean_tab[i + 1];
			end
			fill--;
		end
		r.count = 8'(fill);
		return r;
	endfunction

	function automatic string show(input table_result_t r);
		return $sformatf("st=%0d idx=%0d s=%0d/%0d/%0d mean=%0d cnt=%0d pad=%0h",
			r.status, r.index, r.first, r.second, r.third, r.mean, r.count, r.pad);
	endfunction

	// Compare result words first, then log the command taken on this edge
	always @(posedge clk) begin : watch
		table_result_t got;
		table_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = table_result_t'(m_axis_tdata);
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: result word with nothing pending: %s", $realtime, show(got));
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (got.status == STATUS_FULL)
						full_count++;
					if (got.status == STATUS_MISS)
						miss_count++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t: result mismatch\n  expected %s\n  actual   %s",
								$realtime, show(want), show(got));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(table_apply(s_axis_tuser, s_axis_tdata[30:0],
					s_axis_tdata[40:31], s_axis_tdata[50:41], s_axis_tdata[60:51]));
		end
	end

endmodule

// ===== verif/keyed_record_table_top_tb.sv =====
// ---------------------------------------------------------------------------
// keyed_record_table_top_tb
// Drives table commands into the record table with random gaps on both ports:
// a short directed pass over the corner cases, then fill-to-full and mixed
// segments with keys drawn mostly from a small pool so searches hit often.
// ---------------------------------------------------------------------------
module keyed_record_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import krt_pkg::*;

	localparam int              CYCLE_LIMIT   = 1_000_000;
	localparam int              RANDOM_ITEMS  = 700;
	localparam int              MIXED_LEN     = 60;
	localparam int              POOL_SIZE     = 16;
	localparam int              DRAIN_CYCLES  = 300;
	localparam logic [OP_W-1:0] OP_SPARE_LO   = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI   = 3'd7;
	localparam logic [KEY_W-1:0] KEY_TOP      = 31'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_ODD_BITS = 31'h2AAA_AAAA;
	localparam logic [KEY_W-1:0] KEY_EVN_BITS = 31'h5555_5555;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [63:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;

	int fail_count;
	int pending;
	int checked_count;
	int full_count;
	int miss_count;
	int cycle_count = 0;
	int op_sent [8];
	int issued = 0;
	bit steady_run = 1'b0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	keyed_record_table_top #(
		.CAPACITY(CAPACITY_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	keyed_record_table_checker #(
		.CAPACITY(CAPACITY_DEF)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.fail_count(fail_count),
		.pending(pending),
		.checked_count(checked_count),
		.full_count(full_count),
		.miss_count(miss_count)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyed_record_table_top_tb: errors");
			$finish;
		end
	end

	// Idle length: mostly short, now and then long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SCORE_W-1:0] pick_score();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return SCORE_W'($urandom_range(0, 1000));
		else if (r < 95)
			return r[0] ? SCORE_W'(1000) : '0;
		return SCORE_W'($urandom_range(1001, 1023));
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 90)
			return KEY_W'($urandom);
		return r[0] ? KEY_TOP : '0;
	endfunction

	// Receiver: random stalls, no new ones started during steady stretches
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!steady_run && $urandom_range(0, 99) < 20)
					stall_left = idle_length() + 1;
			end
		end
	end

	// Present one command word and hold it until taken
	task automatic send_command(
		input logic [OP_W-1:0]    op,
		input logic [KEY_W-1:0]   key,
		input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b,
		input logic [SCORE_W-1:0] c
	);
		int gap;
		gap = steady_run ? 0 : idle_length();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {3'b000, c, b, a, key};
		op_sent[op]++;
		issued++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random(input logic [OP_W-1:0] op);
		send_command(op, pick_key(), pick_score(), pick_score(), pick_score());
	endtask

	initial begin : stimulus
		int r;
		int seg;
		logic [OP_W-1:0] op;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, extremes, duplicates, shifts, unused codes
		send_command(OP_LOOKUP, '0, '0, '0, '0);
		send_command(OP_DELETE, KEY_TOP, '0, '0, '0);
		send_command(OP_UPDATE, KEY_ODD_BITS, 10'd1000, 10'd1000, 10'd1000);
		send_command(OP_APPEND, '0, '0, '0, '0);
		send_command(OP_APPEND, KEY_TOP, 10'd1000, 10'd1000, 10'd1000);
		send_command(OP_APPEND, KEY_ODD_BITS, 10'd1023, 10'd1023, 10'd1023);
		send_command(OP_APPEND, KEY_EVN_BITS, 10'd1, 10'd2, 10'd2);
		send_command(OP_APPEND, '0, 10'd5, 10'd6, 10'd7);
		send_command(OP_LOOKUP, '0, '0, '0, '0);
		send_command(OP_UPDATE, '0, 10'd999, 10'd0, 10'd1);
		send_command(OP_LOOKUP, KEY_TOP, '0, '0, '0);
		send_command(OP_DELETE, KEY_TOP, '0, '0, '0);
		send_command(OP_LOOKUP, KEY_EVN_BITS, '0, '0, '0);
		send_command(OP_DELETE, '0, '0, '0, '0);
		send_command(OP_LOOKUP, '0, '0, '0, '0);
		send_command(OP_SPARE_LO, KEY_TOP, 10'd1023, 10'd1023, 10'd1023);
		send_command(OP_SPARE_LO + 3'd1, '0, '0, '0, '0);
		send_command(OP_SPARE_HI, KEY_EVN_BITS, 10'd512, 10'd256, 10'd128);
		send_command(OP_DELETE, '0, '0, '0, '0);
		send_command(OP_UPDATE, KEY_EVN_BITS, 10'd1023, 10'd1023, 10'd1022);
		send_command(OP_CLEAR, KEY_TOP, 10'd1023, 10'd1023, 10'd1023);
		send_command(OP_LOOKUP, KEY_ODD_BITS, '0, '0, '0);
		send_command(OP_APPEND, KEY_ODD_BITS, 10'd333, 10'd334, 10'd335);

		// Random: every third segment fills past capacity, the rest are mixed
		seg = 0;
		while (issued < RANDOM_ITEMS) begin
			steady_run = ($urandom_range(0, 3) == 0);
			if (seg % 3 == 0) begin
				send_random(OP_CLEAR);
				repeat (CAPACITY_DEF + 3)
					send_random(OP_APPEND);
			end else begin
				repeat (MIXED_LEN) begin
					r = $urandom_range(0, 99);
					if (r < 2)
						op = OP_CLEAR;
					else if (r < 37)
						op = OP_APPEND;
					else if (r < 57)
						op = OP_DELETE;
					else if (r < 72)
						op = OP_UPDATE;
					else if (r < 95)
						op = OP_LOOKUP;
					else
						op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
					send_random(op);
				end
			end
			seg++;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		steady_run = 1'b0;

		// Drain, then allow for any stray word
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d commands: %0d clear, %0d append, %0d delete, %0d update, %0d lookup",
			issued, op_sent[OP_CLEAR], op_sent[OP_APPEND], op_sent[OP_DELETE],
			op_sent[OP_UPDATE], op_sent[OP_LOOKUP]);
		$display("%0d unused-code commands; %0d words checked, %0d table full, %0d key miss",
			op_sent[OP_SPARE_LO] + op_sent[OP_SPARE_LO + 3'd1] + op_sent[OP_SPARE_HI],
			checked_count, full_count, miss_count);
		if (fail_count == 0)
			$display("keyed_record_table_top_tb: clean");
		else
			$display("keyed_record_table_top_tb: errors");
		$finish;
	end

endmodule
